// ----- hw/rtl/rrl_pkg.sv -----
package rrl_pkg;

   localparam int MAX_WINDOW_DEF = 1024;

   localparam int TIME_W = 63;   // arrival and release times, ns
   localparam int MR_W   = 11;   // max_requests
   localparam int PS_W   = 16;   // period_seconds
   localparam int NS_W   = 30;   // one second in ns
   localparam int PNS_W  = PS_W + NS_W;

   localparam int TDATA_W    = 64;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_REQUESTS   = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PERIOD_SECONDS = 1'b1;

   localparam logic [NS_W-1:0]   NS_PER_SEC = 30'd1000000000;
   localparam logic [TIME_W-1:0] TIME_MAX   = '1;

   // per-transaction control decided on the request side
   typedef struct packed {
      logic window;   // window mode (period_seconds == 1)
      logic pass;     // one of the first requests of the window
      logic fwd;      // ring slot is being written in the same cycle
   } admit_type;

   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
   endfunction

   function automatic logic [TIME_W-1:0] max2(input logic [TIME_W-1:0] a,
                                               input logic [TIME_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

endpackage

// ----- hw/rtl/rrl_ram.sv -----
module rrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/rrl_admit.sv -----
module rrl_admit #(
   parameter int MAX_WINDOW = rrl_pkg::MAX_WINDOW_DEF,
   parameter int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic                     window_mode,
   input  logic [rrl_pkg::MR_W-1:0] max_requests,
   input  logic                     cfg_clear,
   input  logic                     wr_en,
   input  logic [PTR_W-1:0]         wr_addr,
   output logic [PTR_W-1:0]         rd_addr,
   output rrl_pkg::admit_type       info
);
   import rrl_pkg::*;

   localparam int CNT_W = $clog2(MAX_WINDOW + 1);

   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] seen_ff, seen_in;
   logic [CNT_W-1:0] win_size, p_cur, p_inc, p_next;

   // effective window: zero acts as one, clipped to the ring depth
   always_comb begin
      if (max_requests == '0) begin
         win_size = CNT_W'(1);
      end else if (32'(max_requests) > 32'(MAX_WINDOW)) begin
         win_size = CNT_W'(MAX_WINDOW);
      end else begin
         win_size = CNT_W'(max_requests);
      end
   end

   assign p_cur  = (CNT_W'(ptr_ff) >= win_size) ? '0 : CNT_W'(ptr_ff);
   assign p_inc  = p_cur + CNT_W'(1);
   assign p_next = (p_inc >= win_size) ? '0 : p_inc;

   assign rd_addr     = p_cur[PTR_W-1:0];
   assign info.window = window_mode;
   assign info.pass   = seen_ff < win_size;
   assign info.fwd    = wr_en && (wr_addr == rd_addr);

   always_comb begin
      ptr_in  = ptr_ff;
      seen_in = seen_ff;
      if (cfg_clear) begin
         ptr_in  = '0;
         seen_in = '0;
      end else if (accept && window_mode) begin
         ptr_in = p_next[PTR_W-1:0];
         if (info.pass) begin
            seen_in = seen_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         seen_ff <= '0;
      end else begin
         ptr_ff  <= ptr_in;
         seen_ff <= seen_in;
      end
   end

   a_slot_in_window: assert property (@(posedge clock) disable iff (reset)
      accept && window_mode |-> p_cur < win_size)
      else $error("ring slot outside window");

   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(seen_ff) <= CNT_W'(MAX_WINDOW))
      else $error("seen count beyond ring depth");

   a_clear_restarts: assert property (@(posedge clock) disable iff (reset)
      cfg_clear |=> (seen_ff == '0) && (ptr_ff == '0))
      else $error("window not restarted after max_requests write");

endmodule

// ----- hw/rtl/rrl_release.sv -----
module rrl_release #(
   parameter int PTR_W = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [rrl_pkg::TIME_W-1:0] arrival,
   input  rrl_pkg::admit_type         info,
   input  logic [PTR_W-1:0]           addr,
   input  logic [rrl_pkg::TIME_W-1:0] ring_rdata,
   input  logic [rrl_pkg::PNS_W-1:0]  period_ns,
   output logic                       in_ready,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [rrl_pkg::TIME_W-1:0] release_time,
   output logic                       ring_we,
   output logic [PTR_W-1:0]           ring_waddr,
   output logic [rrl_pkg::TIME_W-1:0] ring_wdata
);
   import rrl_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   logic [TIME_W-1:0] s1_arrival_ff;
   admit_type         s1_info_ff;
   logic [PTR_W-1:0]  s1_addr_ff;
   logic              out_valid_ff, out_valid_in;
   logic [TIME_W-1:0] out_time_ff;
   logic [TIME_W-1:0] last_release_ff, next_allowed_ff;

   logic              advance;
   logic [TIME_W-1:0] ring_val, win_rel, sp_rel, rel;

   assign advance  = s1_valid_ff && (!out_valid_ff || out_ready);
   assign in_ready = !s1_valid_ff || advance;

   // slot written by the previous transaction comes from last_release
   assign ring_val = s1_info_ff.fwd ? last_release_ff : ring_rdata;
   assign win_rel  = s1_info_ff.pass ? s1_arrival_ff :
                     max2(max2(sat_add(ring_val, TIME_W'(NS_PER_SEC)), last_release_ff),
                          s1_arrival_ff);
   assign sp_rel   = max2(s1_arrival_ff, next_allowed_ff);
   assign rel      = s1_info_ff.window ? win_rel : sp_rel;

   assign ring_we    = advance && s1_info_ff.window;
   assign ring_waddr = s1_addr_ff;
   assign ring_wdata = rel;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         last_release_ff <= '0;
         next_allowed_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (ring_we) begin
            last_release_ff <= rel;
         end
         if (advance && !s1_info_ff.window) begin
            next_allowed_ff <= sat_add(sp_rel, TIME_W'(period_ns));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_arrival_ff <= arrival;
         s1_info_ff    <= info;
         s1_addr_ff    <= addr;
      end
      if (advance) begin
         out_time_ff <= rel;
      end
   end

   assign out_valid    = out_valid_ff;
   assign release_time = out_time_ff;

   a_not_early: assert property (@(posedge clock) disable iff (reset)
      advance |-> rel >= s1_arrival_ff)
      else $error("release before arrival");

   a_window_order: assert property (@(posedge clock) disable iff (reset)
      advance && s1_info_ff.window && !s1_info_ff.pass |-> rel >= last_release_ff)
      else $error("window release out of order");

   a_ring_write_valid: assert property (@(posedge clock) disable iff (reset)
      ring_we |-> s1_valid_ff && (!out_valid_ff || out_ready))
      else $error("ring written without a transaction leaving the stage");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      accept |-> !s1_valid_ff || advance)
      else $error("request stage overwritten");

endmodule

// ----- hw/rtl/request_rate_limiter.sv -----
// Request rate limiter.
// req_*: one transaction per request, tdata[62:0] = arrival time in ns
//   (non-decreasing). rsp_*: one transaction per request, in order,
//   tdata[62:0] = release time in ns, saturating at 2^63-1.
// csr_*: write-only registers, index 0 max_requests (restarts the window),
//   index 1 period_seconds; write only while idle, not enforced by the block.
// period_seconds == 1: sliding window, at most max_requests releases in any
//   one second, using a ring of past releases in a RAM. Otherwise releases
//   are spaced at least period_seconds apart.
// Throughput: one transaction per cycle while rsp does not stall. A request is
//   held in the working stage (ring read as it is accepted), then in the
//   result register that drives rsp.
// The ring RAM read can fall in the same cycle as the write of the preceding
//   transaction's release; a same-slot read takes the last release instead.
// Reset clears pointers, counters and the timing state and restores
//   max_requests = 1, period_seconds = 1. The ring has no clearing pass:
//   every slot is written before it is read.
// When rsp stalls, the result register holds and one more request is taken
//   into the working stage; req_tready then drops until rsp drains.
module request_rate_limiter #(
   parameter int MAX_WINDOW = rrl_pkg::MAX_WINDOW_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [rrl_pkg::TDATA_W-1:0]    req_tdata,   // [62:0] arrival_time
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rrl_pkg::TDATA_W-1:0]    rsp_tdata,   // [62:0] release_time
   input  logic                           csr_we,
   input  logic [rrl_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [rrl_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rrl_pkg::*;

   localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   // configuration
   logic [MR_W-1:0]  max_requests_ff;
   logic [PS_W-1:0]  period_seconds_ff;
   logic [PNS_W-1:0] period_ns_ff;      // period_seconds in ns, made at write

   logic              accept, cfg_clear, window_mode;
   admit_type         info;
   logic [PTR_W-1:0]  rd_addr;
   logic [TIME_W-1:0] ring_rdata, ring_wdata, release_time;
   logic              ring_we;
   logic [PTR_W-1:0]  ring_waddr;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_requests_ff   <= MR_W'(1);
         period_seconds_ff <= PS_W'(1);
         period_ns_ff      <= PNS_W'(NS_PER_SEC);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_MAX_REQUESTS: begin
               max_requests_ff <= csr_wdata[MR_W-1:0];
            end
            CSR_PERIOD_SECONDS: begin
               period_seconds_ff <= csr_wdata[PS_W-1:0];
               period_ns_ff      <= PNS_W'(csr_wdata[PS_W-1:0]) * PNS_W'(NS_PER_SEC);
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg_clear   = csr_we && (csr_addr == CSR_MAX_REQUESTS);
   assign window_mode = period_seconds_ff == PS_W'(1);
   assign accept      = req_tvalid && req_tready;

   // ring slot selection and window fill count
   rrl_admit #(
      .MAX_WINDOW (MAX_WINDOW),
      .PTR_W      (PTR_W)
   ) u_admit (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .window_mode  (window_mode),
      .max_requests (max_requests_ff),
      .cfg_clear    (cfg_clear),
      .wr_en        (ring_we),
      .wr_addr      (ring_waddr),
      .rd_addr      (rd_addr),
      .info         (info)
   );

   // ring of past window-mode releases, read as the request is accepted
   rrl_ram #(
      .WIDTH (TIME_W),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (ring_wdata),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ring_rdata)
   );

   // release computation and result register
   rrl_release #(
      .PTR_W (PTR_W)
   ) u_release (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .arrival      (req_tdata[TIME_W-1:0]),
      .info         (info),
      .addr         (rd_addr),
      .ring_rdata   (ring_rdata),
      .period_ns    (period_ns_ff),
      .in_ready     (req_tready),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .release_time (release_time),
      .ring_we      (ring_we),
      .ring_waddr   (ring_waddr),
      .ring_wdata   (ring_wdata)
   );

   assign rsp_tdata = {{(TDATA_W - TIME_W){1'b0}}, release_time};

endmodule

// ----- tb/tb_request_rate_limiter.sv -----
module tb_request_rate_limiter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          W_MAX       = rrl_pkg::MAX_WINDOW_DEF;
   localparam int          T_W         = rrl_pkg::TIME_W;
   localparam logic [63:0] ONE_SEC_NS  = 64'd1_000_000_000;
   localparam logic [63:0] T_TOP       = {1'b0, rrl_pkg::TIME_MAX};
   // cycles without any transaction on either channel before giving up
   localparam int          STALL_LIMIT = 2000;

   typedef logic [T_W-1:0] ns_t;

   // ------------------------------------------------------------------
   // DUT signals; the inputs are driven to known values from time zero
   // ------------------------------------------------------------------
   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [rrl_pkg::TDATA_W-1:0]    req_tdata  = '0;   // [62:0] arrival_time
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [rrl_pkg::TDATA_W-1:0]    rsp_tdata;         // [62:0] release_time
   logic                           csr_we     = 1'b0;
   logic [rrl_pkg::CSR_ADDR_W-1:0] csr_addr   = rrl_pkg::CSR_MAX_REQUESTS;
   logic [rrl_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   request_rate_limiter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Shared testbench state
   // ------------------------------------------------------------------
   ns_t release_q[$];        // predicted release times, oldest first
   int  n_errors    = 0;
   int  n_sent      = 0;
   int  n_checked   = 0;
   int  tx_idle_pct = 0;     // chance per cycle that the sender holds back
   int  rx_stall_pct = 0;    // chance per cycle that the receiver stalls
   int  hold_cycles = 0;     // forced receiver hold-off, counted down per cycle
   int  idle_cycles = 0;
   ns_t exp_rel;

   // idling phases: none, sender only, receiver only, both
   int  tx_phase[4] = '{0, 75, 0, 36};
   int  rx_phase[4] = '{0, 0, 75, 36};

   // ------------------------------------------------------------------
   // Predictor state: shadow of the limiter's registers and history
   // ------------------------------------------------------------------
   ns_t         past_rel[W_MAX];   // window-mode release history
   int          slot_m     = 0;
   int          seen_m     = 0;
   ns_t         prev_rel_m = '0;
   ns_t         next_ok_m  = '0;
   logic [10:0] max_req_m  = 11'd1;
   logic [15:0] period_m   = 16'd1;

   function automatic ns_t sat_sum(input ns_t a, input logic [63:0] b);
      logic [64:0] s;
      s = {2'b00, a} + {1'b0, b};
      return (s > {1'b0, T_TOP}) ? T_TOP[T_W-1:0] : s[T_W-1:0];
   endfunction

   function automatic ns_t later(input ns_t a, input ns_t b);
      return (a > b) ? a : b;
   endfunction

   // Works out the release time of one accepted request and advances
   // the shadow state exactly as the limiter should.
   function automatic ns_t predict_release(input ns_t arr);
      int  w;
      int  p;
      ns_t rel;
      if (period_m == 16'd1) begin
         // window mode; out-of-range sizes are clamped to 1..W_MAX
         w = int'(max_req_m);
         if (w == 0) w = 1;
         if (w > W_MAX) w = W_MAX;
         p = (slot_m >= w) ? 0 : slot_m;
         if (seen_m < w) begin
            // still filling the window: passes untouched
            rel = arr;
            seen_m++;
         end else begin
            rel = later(later(sat_sum(past_rel[p], ONE_SEC_NS), prev_rel_m), arr);
         end
         past_rel[p] = rel;
         p++;
         if (p >= w) p = 0;
         slot_m     = p;
         prev_rel_m = rel;
      end else begin
         // spacing mode; a period of zero only keeps releases in order
         rel       = later(arr, next_ok_m);
         next_ok_m = sat_sum(rel, 64'(period_m) * ONE_SEC_NS);
      end
      return rel;
   endfunction

   // ------------------------------------------------------------------
   // Sender: offers one request, with random idle cycles beforehand.
   // tvalid is left high after acceptance so back-to-back transactions
   // need no second assignment in the same step.
   // ------------------------------------------------------------------
   task automatic send_arrival(input ns_t arr);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, arr};
      do @(posedge clock); while (!req_tready);
      release_q.push_back(predict_release(arr));
      n_sent++;
   endtask

   // Stop offering and wait for every predicted release to come back,
   // plus a margin covering the two-stage pipeline.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (release_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write, only ever issued with the block idle.
   task automatic write_csr(input logic [rrl_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [15:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (addr == rrl_pkg::CSR_MAX_REQUESTS) begin
         // size write restarts the window
         max_req_m = value[10:0];
         seen_m    = 0;
         slot_m    = 0;
      end else begin
         period_m = value;
      end
   endtask

   task automatic set_traffic(input int tx, input int rx);
      tx_idle_pct  = tx;
      rx_stall_pct = rx;
   endtask

   // Next random arrival: mostly non-decreasing with a spread set by
   // step_ns, plus a little noise (steps back, arbitrary 63-bit values,
   // jumps close to the top of the range).
   function automatic ns_t next_arrival(input ns_t prev, input int unsigned step_ns);
      logic [63:0] t;
      int unsigned r;
      r = $urandom_range(99);
      t = {1'b0, prev};
      if (r < 3) begin
         t = {$urandom, $urandom} & T_TOP;
      end else if (r < 6) begin
         if (t >= 64'd2_000_000_000) t = t - $urandom_range(1, 32'd2_000_000_000);
         else t = '0;
      end else if (r < 25) begin
         // same instant as the previous request
      end else if (r < 85) begin
         t = t + $urandom_range(0, step_ns);
      end else if (r < 99) begin
         t = t + $urandom_range(0, 32'd3_000_000_000);
      end else begin
         t = T_TOP - $urandom_range(0, 32'd3_000_000_000);
      end
      if (t > T_TOP) t = T_TOP;
      return t[T_W-1:0];
   endfunction

   function automatic logic [15:0] pick_window();
      int unsigned r;
      logic [10:0] mr;
      r = $urandom_range(9);
      case (r)
         0:       mr = 11'd0;                            // treated as one
         1:       mr = 11'($urandom_range(1025, 2047));  // clamped to full ring
         2, 3, 4: mr = 11'($urandom_range(1, 4));
         5, 6, 7: mr = 11'($urandom_range(5, 32));
         default: mr = 11'($urandom_range(33, 100));
      endcase
      // upper bits of the write data are not part of the size
      return (16'($urandom) & 16'hF800) | {5'b0, mr};
   endfunction

   function automatic int unsigned window_step(input logic [15:0] v);
      int w;
      w = int'(v[10:0]);
      if (w == 0) w = 1;
      if (w > W_MAX) w = W_MAX;
      return 32'd2_000_000_000 / w;
   endfunction

   // ------------------------------------------------------------------
   // Receiver and checker: compares every response transaction with the
   // oldest prediction, then decides tready for the next cycle.
   // ------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            n_checked++;
            if (release_q.size() == 0) begin
               n_errors++;
               $display("%0t: unexpected response, expected none, actual %0d",
                        $time, rsp_tdata[T_W-1:0]);
            end else begin
               exp_rel = release_q.pop_front();
               if (rsp_tdata[T_W-1:0] !== exp_rel) begin
                  n_errors++;
                  $display("%0t: release_time mismatch, expected %0d, actual %0d",
                           $time, exp_rel, rsp_tdata[T_W-1:0]);
               end
            end
         end
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   // Watchdog: a long stretch with no transaction means a hang.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Out of reset: window of one, so the second request waits a second.
   task automatic test_reset_defaults();
      send_arrival(ns_t'(7));
      send_arrival(ns_t'(7));
      drain();
   endtask

   task automatic test_window_directed();
      write_csr(rrl_pkg::CSR_PERIOD_SECONDS, 16'd1);
      write_csr(rrl_pkg::CSR_MAX_REQUESTS, 16'd3);
      // burst at time zero: three pass, the fourth is pushed a second on
      send_arrival(ns_t'(0));
      send_arrival(ns_t'(0));
      send_arrival(ns_t'(0));
      send_arrival(ns_t'(0));
      send_arrival(ns_t'(1));
      send_arrival(ns_t'(500_000_000));
      send_arrival(ns_t'(64'd3_000_000_000));
      // arrival going backwards
      send_arrival(ns_t'(64'd2_000_000_000));
      // release plus one second saturating at the top
      send_arrival(rrl_pkg::TIME_MAX - ns_t'(5));
      send_arrival(rrl_pkg::TIME_MAX);
      send_arrival(rrl_pkg::TIME_MAX);
      // size zero behaves as one
      write_csr(rrl_pkg::CSR_MAX_REQUESTS, 16'd0);
      send_arrival(ns_t'(10));
      send_arrival(ns_t'(10));
      send_arrival(ns_t'(20));
      // size above the ring depth behaves as the full ring
      write_csr(rrl_pkg::CSR_MAX_REQUESTS, 16'd2047);
      send_arrival(ns_t'(1));
      send_arrival(ns_t'(2));
      drain();
   endtask

   task automatic test_spacing_directed();
      // zero spacing: releases only kept in order
      write_csr(rrl_pkg::CSR_PERIOD_SECONDS, 16'd0);
      send_arrival(ns_t'(100));
      send_arrival(ns_t'(50));
      send_arrival(ns_t'(200));
      // widest spacing, next allowed time saturates
      write_csr(rrl_pkg::CSR_PERIOD_SECONDS, 16'hFFFF);
      send_arrival(ns_t'(0));
      send_arrival(rrl_pkg::TIME_MAX - ns_t'(1));
      write_csr(rrl_pkg::CSR_PERIOD_SECONDS, 16'd2);
      send_arrival(rrl_pkg::TIME_MAX);
      drain();
   endtask

   task automatic test_window_random();
      ns_t         t;
      logic [15:0] mr;
      for (int ph = 0; ph < 4; ph++) begin
         set_traffic(tx_phase[ph], rx_phase[ph]);
         write_csr(rrl_pkg::CSR_PERIOD_SECONDS, 16'd1);
         for (int k = 0; k < 2; k++) begin
            mr = pick_window();
            write_csr(rrl_pkg::CSR_MAX_REQUESTS, mr);
            t = ns_t'({$urandom_range(0, 1000), 32'($urandom)});
            for (int i = 0; i < 25; i++) begin
               t = next_arrival(t, window_step(mr));
               send_arrival(t);
            end
         end
      end
      drain();
   endtask

   task automatic test_spacing_random();
      ns_t         t;
      logic [15:0] per;
      int unsigned r;
      int unsigned step;
      for (int ph = 0; ph < 4; ph++) begin
         set_traffic(tx_phase[ph], rx_phase[ph]);
         r = $urandom_range(3);
         case (r)
            0:       per = 16'd0;
            1:       per = 16'($urandom_range(2, 5));
            2:       per = 16'($urandom);
            default: per = 16'hFFFF;
         endcase
         write_csr(rrl_pkg::CSR_PERIOD_SECONDS, per);
         step = (per > 16'd2) ? 32'd4_000_000_000 : 32'(per) * 32'd2_000_000_000;
         if (step == 0) step = 1000;
         t = ns_t'({$urandom_range(0, 1000), 32'($urandom)});
         for (int i = 0; i < 20; i++) begin
            t = next_arrival(t, step);
            send_arrival(t);
         end
      end
      drain();
   endtask

   // Each mode must carry on from its own history after the other ran.
   task automatic test_mode_switch();
      ns_t t;
      t = '0;
      set_traffic(36, 36);
      write_csr(rrl_pkg::CSR_MAX_REQUESTS, 16'd4);
      write_csr(rrl_pkg::CSR_PERIOD_SECONDS, 16'd1);
      for (int i = 0; i < 30; i++) begin
         t = next_arrival(t, 32'd500_000_000);
         send_arrival(t);
      end
      write_csr(rrl_pkg::CSR_PERIOD_SECONDS, 16'd3);
      for (int i = 0; i < 15; i++) begin
         t = next_arrival(t, 32'd4_000_000_000);
         send_arrival(t);
      end
      write_csr(rrl_pkg::CSR_PERIOD_SECONDS, 16'd1);
      for (int i = 0; i < 15; i++) begin
         t = next_arrival(t, 32'd500_000_000);
         send_arrival(t);
      end
      write_csr(rrl_pkg::CSR_PERIOD_SECONDS, 16'd3);
      for (int i = 0; i < 15; i++) begin
         t = next_arrival(t, 32'd4_000_000_000);
         send_arrival(t);
      end
      drain();
   endtask

   // Receiver holds off for a long stretch while requests keep coming:
   // the pipeline fills and req_tready must drop without losing anything.
   task automatic test_backpressure();
      ns_t t;
      t = ns_t'(1000);
      set_traffic(0, 0);
      write_csr(rrl_pkg::CSR_MAX_REQUESTS, 16'd2);
      write_csr(rrl_pkg::CSR_PERIOD_SECONDS, 16'd1);
      hold_cycles = 300;
      for (int i = 0; i < 40; i++) begin
         t = next_arrival(t, 32'd1_000_000_000);
         send_arrival(t);
      end
      drain();
   endtask

   // Large window: enough requests to fill it, wrap and read back its first slots.
   task automatic test_large_window();
      ns_t t;
      t = '0;
      set_traffic(0, 36);
      write_csr(rrl_pkg::CSR_PERIOD_SECONDS, 16'd1);
      write_csr(rrl_pkg::CSR_MAX_REQUESTS, 16'd480);
      for (int i = 0; i < 500; i++) begin
         t = next_arrival(t, 32'd2_000_000);
         send_arrival(t);
      end
      drain();
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_window_directed();
      test_spacing_directed();
      test_window_random();
      test_spacing_random();
      test_mode_switch();
      test_backpressure();
      test_large_window();
      drain();
      $display("Window sizes 0..2047 incl. a wrapped 480-slot window, spacing 0..65535 s,");
      $display("saturation, backward arrivals, mode switches, stalls: %0d sent, %0d checked",
               n_sent, n_checked);
      if (n_errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
